// ===== rtl/pfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, codes and compare helpers for the Pareto front archive.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int NUM_OBJ = 5;
  localparam int COST_W  = 32;
  localparam int ACT_W   = 3;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // register index as seen on paddr[2]
  localparam logic REG_ACTIVE_OBJ = 1'b0;
  localparam logic [ACT_W-1:0] ACT_OBJ_RESET = 3'd2;

  typedef logic [NUM_OBJ-1:0][COST_W-1:0] cost_vec_t;
  typedef logic [NUM_OBJ-1:0] obj_mask_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DOMINATED = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_CHK,
    S_SHIFT,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic cmp;    // latch dominance flags against the candidate
    logic shift;  // close the first hole in the chain
  } cell_ctrl_t;

  // Objectives taken part in the compare; zero counts as one, excess clamps.
  function automatic obj_mask_t obj_mask(logic [ACT_W-1:0] act);
    logic [ACT_W-1:0] n;
    obj_mask_t        m;
    n = act;
    if (n == '0) n = ACT_W'(1);
    if (n > ACT_W'(NUM_OBJ)) n = ACT_W'(NUM_OBJ);
    for (int o = 0; o < NUM_OBJ; o++) begin
      m[o] = (ACT_W'(o) < n);
    end
    return m;
  endfunction

  // a is no worse than b over every enabled objective
  function automatic logic no_worse(cost_vec_t a, cost_vec_t b, obj_mask_t mask);
    logic ok;
    ok = 1'b1;
    for (int o = 0; o < NUM_OBJ; o++) begin
      if (mask[o] && (a[o] > b[o])) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ===== rtl/pfa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_cell
// One archive slot: holds a cost vector, compares it with the candidate and
// takes its right neighbour's contents while a hole lies at or before it.
// ----------------------------------------------------------------------------
module pfa_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  pfa_pkg::cell_ctrl_t ctrl,
  input  pfa_pkg::cost_vec_t cand,
  input  pfa_pkg::obj_mask_t mask,
  input  logic               live,
  input  logic               load_cand,
  input  logic               hole_in,
  input  pfa_pkg::cost_vec_t next_costs,
  input  logic               next_rem,
  output pfa_pkg::cost_vec_t costs,
  output logic               rem,
  output logic               dom,
  output logic               hole_out
);
  import pfa_pkg::*;

  cost_vec_t costs_r, costs_nxt;
  logic      rem_r, rem_nxt;
  logic      dom_r, dom_nxt;
  logic      shift_en;

  // prefix of removal flags ripples down the chain
  assign hole_out = hole_in | rem_r;
  assign shift_en = ctrl.shift & hole_out;

  always_comb begin
    costs_nxt = costs_r;
    rem_nxt   = rem_r;
    dom_nxt   = dom_r;
    if (ctrl.cmp) begin
      dom_nxt = live & no_worse(costs_r, cand, mask);
      rem_nxt = live & no_worse(cand, costs_r, mask);
    end else if (shift_en) begin
      costs_nxt = next_costs;
      rem_nxt   = next_rem;
    end else if (load_cand) begin
      costs_nxt = cand;
      rem_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    costs_r <= costs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 1'b0;
      dom_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      dom_r <= dom_nxt;
    end
  end

  assign costs = costs_r;
  assign rem   = rem_r;
  assign dom   = dom_r;

endmodule

// ===== rtl/pareto_front_archive_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_front_archive_unit
// Non-dominated archive of cost vectors kept in insertion order in a chain
// of slot cells; offers are compared in all cells at once and removed
// entries are squeezed out one per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | req_type, entry_index, cost_0..4
//  out_    | output    | out_valid / out_ready  | status, removed_count, stored_count,
//          |           |                        | entry_cost_0..4
//  cfg     | input     | psel, penable, pready  | paddr, pwdata, prdata
//
// Offer: compare, check, then one compaction shift per removed entry and the
// append; a dominated offer skips the shifts. Read: the entry is staged. One
// request in flight; the next is taken the cycle after the result is loaded
// into the output register, and the block holds in its response state while
// that register is full and out_ready is low. Synchronous active-low reset
// empties the front and sets two active objectives; no clearing pass.
// ----------------------------------------------------------------------------
module pareto_front_archive_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [3:0]                  in_entry_index,
  input  logic [31:0]                 in_cost_0,
  input  logic [31:0]                 in_cost_1,
  input  logic [31:0]                 in_cost_2,
  input  logic [31:0]                 in_cost_3,
  input  logic [31:0]                 in_cost_4,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [4:0]                  out_removed_count,
  output logic [4:0]                  out_stored_count,
  output logic [31:0]                 out_entry_cost_0,
  output logic [31:0]                 out_entry_cost_1,
  output logic [31:0]                 out_entry_cost_2,
  output logic [31:0]                 out_entry_cost_3,
  output logic [31:0]                 out_entry_cost_4,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfa_pkg::ADDR_W-1:0]  paddr,
  input  logic [pfa_pkg::DATA_W-1:0]  pwdata,
  output logic [pfa_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import pfa_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // control
  state_t            state_r, state_nxt;
  cell_ctrl_t        cell_ctrl;
  logic              in_fire;
  logic              resp_fire;
  logic              append_en;

  // request
  logic [3:0]        req_idx_r, req_idx_nxt;
  cost_vec_t         cand_r, cand_nxt;

  // archive bookkeeping
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt;
  logic [ACT_W-1:0]  act_obj_r, act_obj_nxt;
  obj_mask_t         mask;

  // result staging and output register
  status_t           res_status_r, res_status_nxt;
  logic [CNT_W-1:0]  res_removed_r, res_removed_nxt;
  logic [CNT_W-1:0]  res_size_r, res_size_nxt;
  cost_vec_t         res_costs_r, res_costs_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_removed_r, out_removed_nxt;
  logic [CNT_W-1:0]  out_size_r, out_size_nxt;
  cost_vec_t         out_costs_r, out_costs_nxt;

  // chain wiring
  cost_vec_t         cell_costs [CAPACITY+1];
  logic [CAPACITY:0] rem_vec;
  logic [CAPACITY:0] hole_chain;
  logic [CAPACITY-1:0] dom_vec;
  logic [CAPACITY-1:0] live_vec;
  logic [CAPACITY-1:0] load_vec;
  logic [CAPACITY-1:0] rd_sel;
  logic              any_dom;
  logic              any_rem;
  cost_vec_t         rd_costs;
  logic              rd_hit;
  logic              cfg_wr;

  assign mask = obj_mask(act_obj_r);

  // -------------------------------------------------------------------------
  // cell chain
  // -------------------------------------------------------------------------
  assign hole_chain[0]        = 1'b0;
  assign rem_vec[CAPACITY]    = 1'b0;
  assign cell_costs[CAPACITY] = cand_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign live_vec[i] = (CNT_W'(i) < cnt_r);
    assign load_vec[i] = append_en & (cnt_r == CNT_W'(i));
    assign rd_sel[i]   = (32'(req_idx_r) == 32'(i));

    pfa_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .cand       (cand_r),
      .mask       (mask),
      .live       (live_vec[i]),
      .load_cand  (load_vec[i]),
      .hole_in    (hole_chain[i]),
      .next_costs (cell_costs[i+1]),
      .next_rem   (rem_vec[i+1]),
      .costs      (cell_costs[i]),
      .rem        (rem_vec[i]),
      .dom        (dom_vec[i]),
      .hole_out   (hole_chain[i+1])
    );
  end

  assign any_dom = |dom_vec;
  assign any_rem = hole_chain[CAPACITY];
  assign rd_hit  = (32'(req_idx_r) < 32'(cnt_r));

  always_comb begin
    rd_costs = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_sel[i]) rd_costs = rd_costs | cell_costs[i];
    end
  end

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  assign in_fire   = in_valid & in_ready;
  assign resp_fire = (state_r == S_RESP) & (~out_valid_r | out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = in_req_type ? S_READ : S_CMP;
      S_CMP:   state_nxt = S_CHK;
      S_CHK:   state_nxt = any_dom ? S_RESP : S_SHIFT;
      S_SHIFT: if (!any_rem) state_nxt = S_RESP;
      S_READ:  state_nxt = S_RESP;
      S_RESP:  if (resp_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cell_ctrl.cmp   = 1'b0;
    cell_ctrl.shift = 1'b0;
    append_en       = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_CMP:   cell_ctrl.cmp = 1'b1;
      S_SHIFT: begin
        cell_ctrl.shift = any_rem;
        append_en       = ~any_rem & (cnt_r != CNT_W'(CAPACITY));
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // datapath
  // -------------------------------------------------------------------------
  always_comb begin
    req_idx_nxt     = req_idx_r;
    cand_nxt        = cand_r;
    cnt_nxt         = cnt_r;
    removed_nxt     = removed_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    res_size_nxt    = res_size_r;
    res_costs_nxt   = res_costs_r;

    if (in_fire) begin
      req_idx_nxt  = in_entry_index;
      cand_nxt[0]  = in_cost_0;
      cand_nxt[1]  = in_cost_1;
      cand_nxt[2]  = in_cost_2;
      cand_nxt[3]  = in_cost_3;
      cand_nxt[4]  = in_cost_4;
      removed_nxt  = '0;
    end

    case (state_r)
      S_CHK: begin
        if (any_dom) begin
          res_status_nxt  = ST_DOMINATED;
          res_removed_nxt = '0;
          res_size_nxt    = cnt_r;
          res_costs_nxt   = '0;
        end
      end
      S_SHIFT: begin
        if (any_rem) begin
          cnt_nxt     = cnt_r - CNT_W'(1);
          removed_nxt = removed_r + CNT_W'(1);
        end else if (append_en) begin
          cnt_nxt         = cnt_r + CNT_W'(1);
          res_status_nxt  = ST_ACCEPTED;
          res_removed_nxt = removed_r;
          res_size_nxt    = cnt_r + CNT_W'(1);
          res_costs_nxt   = '0;
        end else begin
          res_status_nxt  = ST_FULL;
          res_removed_nxt = '0;
          res_size_nxt    = cnt_r;
          res_costs_nxt   = '0;
        end
      end
      S_READ: begin
        res_removed_nxt = '0;
        res_size_nxt    = cnt_r;
        if (rd_hit) begin
          res_status_nxt = ST_READ_OK;
          res_costs_nxt  = rd_costs;
        end else begin
          res_status_nxt = ST_BAD_INDEX;
          res_costs_nxt  = '0;
        end
      end
      default: ;
    endcase
  end

  // output register: loaded from staging, freed by the sink
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_size_nxt    = out_size_r;
    out_costs_nxt   = out_costs_r;
    if (resp_fire) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = res_status_r;
      out_removed_nxt = res_removed_r;
      out_size_nxt    = res_size_r;
      out_costs_nxt   = res_costs_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // configuration port
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    act_obj_nxt = act_obj_r;
    if (cfg_wr && (paddr[2] == REG_ACTIVE_OBJ)) act_obj_nxt = pwdata[ACT_W-1:0];
  end

  assign prdata = (paddr[2] == REG_ACTIVE_OBJ) ? DATA_W'(act_obj_r) : '0;

  // -------------------------------------------------------------------------
  // registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      removed_r   <= '0;
      act_obj_r   <= ACT_OBJ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      removed_r   <= removed_nxt;
      act_obj_r   <= act_obj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_idx_r     <= req_idx_nxt;
    cand_r        <= cand_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    res_size_r    <= res_size_nxt;
    res_costs_r   <= res_costs_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_size_r    <= out_size_nxt;
    out_costs_r   <= out_costs_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_count = 5'(out_removed_r);
  assign out_stored_count  = 5'(out_size_r);
  assign out_entry_cost_0  = out_costs_r[0];
  assign out_entry_cost_1  = out_costs_r[1];
  assign out_entry_cost_2  = out_costs_r[2];
  assign out_entry_cost_3  = out_costs_r[3];
  assign out_entry_cost_4  = out_costs_r[4];

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("front size above capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    append_en |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("append did not grow the front");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_CMP) || (state_r == S_READ))
    else $error("accepted request not dispatched");

  a_full_removes_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> out_removed_r == '0)
    else $error("dropped candidate reports removals");

endmodule

// ===== tb/tb_pareto_front_archive_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pareto_front_archive_unit
// Self-checking bench for the Pareto front archive. Offers and reads are
// driven over valid/ready with random gaps on both sides. An in-bench model
// of the front predicts each result, and each result is compared field by
// field. The objective count is swept through every register value between
// phases. The stimulus mixes trade-off vectors, improved copies of stored
// entries, sweeping candidates, noise and reads, so the front fills, drops
// candidates and compacts.
// ----------------------------------------------------------------------------
module tb_pareto_front_archive_unit;
  import pfa_pkg::*;

  localparam int ARCHIVE_DEPTH  = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 100;
  localparam int PHASE_ITEMS    = 47;
  localparam logic [ADDR_W-1:0] ADDR_ACTIVE_OBJ = {REG_ACTIVE_OBJ, 2'b00};

  typedef struct packed {
    logic      req_type;
    logic [3:0] index;
    cost_vec_t costs;
  } request_t;

  typedef struct packed {
    status_t   status;
    logic [4:0] removed;
    logic [4:0] size;
    cost_vec_t costs;
  } result_t;

  // Front model plus the queue of results still owed by the block
  class archive_scoreboard;
    cost_vec_t   front[ARCHIVE_DEPTH];
    int unsigned front_len;
    logic [2:0]  active_setting;
    result_t     awaited[$];
    int unsigned errors;
    int unsigned tally[5];
    int unsigned widest_removal;
    int unsigned largest_front;

    function new();
      front_len      = 0;
      active_setting = ACT_OBJ_RESET;
      errors         = 0;
      widest_removal = 0;
      largest_front  = 0;
      foreach (tally[s]) tally[s] = 0;
    endfunction

    function void set_objectives(logic [2:0] value);
      active_setting = value;
    endfunction

    function int objective_count();
      int n;
      n = active_setting;
      if (n == 0) n = 1;
      if (n > NUM_OBJ) n = NUM_OBJ;
      return n;
    endfunction

    // a is no worse than b over the first n objectives
    function bit weakly_below(cost_vec_t a, cost_vec_t b, int n);
      for (int o = 0; o < n; o++) begin
        if (a[o] > b[o]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(request_t req);
      result_t exp;
      int      n;
      int      keep;
      bit      beaten;
      exp = '0;
      if (req.req_type) begin
        if (req.index < front_len) begin
          exp.status = ST_READ_OK;
          exp.costs  = front[req.index];
        end else begin
          exp.status = ST_BAD_INDEX;
        end
      end else begin
        n      = objective_count();
        beaten = 1'b0;
        for (int i = 0; i < front_len; i++) begin
          if (weakly_below(front[i], req.costs, n)) beaten = 1'b1;
        end
        if (beaten) begin
          exp.status = ST_DOMINATED;
        end else begin
          keep = 0;
          for (int i = 0; i < front_len; i++) begin
            if (weakly_below(req.costs, front[i], n)) begin
              exp.removed = exp.removed + 5'd1;
            end else begin
              front[keep] = front[i];
              keep++;
            end
          end
          front_len = keep;
          // still full means nothing was squeezed out
          if (front_len >= ARCHIVE_DEPTH) begin
            exp.status = ST_FULL;
          end else begin
            front[front_len] = req.costs;
            front_len++;
            exp.status = ST_ACCEPTED;
          end
        end
      end
      exp.size = 5'(front_len);
      awaited = {awaited, exp};
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result transaction with none outstanding, status %0d",
                 $time, got.status);
        return;
      end
      exp = awaited.pop_front();
      tally[exp.status]++;
      if (exp.removed > widest_removal) widest_removal = exp.removed;
      if (exp.size > largest_front) largest_front = exp.size;
      compare("status", 32'(exp.status), 32'(got.status));
      compare("removed_count", 32'(exp.removed), 32'(got.removed));
      compare("stored_count", 32'(exp.size), 32'(got.size));
      for (int o = 0; o < NUM_OBJ; o++) begin
        compare($sformatf("entry_cost_%0d", o), exp.costs[o], got.costs[o]);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_req_type;
  logic [3:0]          in_entry_index;
  logic [31:0]         in_cost_0, in_cost_1, in_cost_2, in_cost_3, in_cost_4;
  logic                out_valid;
  logic                out_ready;
  logic [2:0]          out_status;
  logic [4:0]          out_removed_count;
  logic [4:0]          out_stored_count;
  logic [31:0]         out_entry_cost_0, out_entry_cost_1, out_entry_cost_2;
  logic [31:0]         out_entry_cost_3, out_entry_cost_4;
  logic                psel, penable, pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  archive_scoreboard   sb = new();
  bit                  quiet;
  bit                  rx_hold_req;
  int unsigned         stall_cycles;

  pareto_front_archive_unit #(.CAPACITY(ARCHIVE_DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_cost_0         (in_cost_0),
    .in_cost_1         (in_cost_1),
    .in_cost_2         (in_cost_2),
    .in_cost_3         (in_cost_3),
    .in_cost_4         (in_cost_4),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_stored_count  (out_stored_count),
    .out_entry_cost_0  (out_entry_cost_0),
    .out_entry_cost_1  (out_entry_cost_1),
    .out_entry_cost_2  (out_entry_cost_2),
    .out_entry_cost_3  (out_entry_cost_3),
    .out_entry_cost_4  (out_entry_cost_4),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // both channels observed on the rising edge
  always @(posedge clk) begin : monitor
    request_t req;
    result_t  res;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        req.req_type = in_req_type;
        req.index    = in_entry_index;
        req.costs    = {in_cost_4, in_cost_3, in_cost_2, in_cost_1, in_cost_0};
        sb.note_request(req);
      end
      if (out_valid && out_ready) begin
        res.status  = status_t'(out_status);
        res.removed = out_removed_count;
        res.size    = out_stored_count;
        res.costs   = {out_entry_cost_4, out_entry_cost_3, out_entry_cost_2,
                       out_entry_cost_1, out_entry_cost_0};
        sb.check_result(res);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_pareto_front_archive_unit failed");
      $finish;
    end
  end

  // result side pacing: random stalls, ready stretches, one long hold-off
  initial begin : rx_pacing
    int unsigned span;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 15);
        repeat (span - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 30);
        repeat (span - 1) @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(request_t r);
    in_valid       <= 1'b1;
    in_req_type    <= r.req_type;
    in_entry_index <= r.index;
    in_cost_0      <= r.costs[0];
    in_cost_1      <= r.costs[1];
    in_cost_2      <= r.costs[2];
    in_cost_3      <= r.costs[3];
    in_cost_4      <= r.costs[4];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // write the objective count, then read it back
  task automatic set_active_objectives(logic [2:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_OBJ;
    pwdata  <= {29'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_objectives(value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.compare("active_objectives readback", {29'd0, value}, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic request_t offer(logic [31:0] c0, logic [31:0] c1,
                                     logic [31:0] c2, logic [31:0] c3,
                                     logic [31:0] c4);
    request_t r;
    r.req_type = 1'b0;
    r.index    = 4'($urandom);
    r.costs    = {c4, c3, c2, c1, c0};
    return r;
  endfunction

  function automatic request_t read_at(logic [3:0] idx);
    request_t r;
    r.req_type = 1'b1;
    r.index    = idx;
    for (int o = 0; o < NUM_OBJ; o++) r.costs[o] = $urandom;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int          n;
    int          pick;
    int unsigned base;
    n    = sb.objective_count();
    pick = $urandom_range(0, 99);
    r    = offer($urandom, $urandom, $urandom, $urandom, $urandom);
    if (pick < 22) begin
      r = read_at(4'($urandom_range(0, 15)));
    end else if (pick < 34) begin
      // noise: full-range costs as drawn
    end else if (pick < 52 && sb.front_len > 0) begin
      // copy of a stored entry, some objectives improved
      r.costs = sb.front[$urandom_range(0, sb.front_len - 1)];
      for (int o = 0; o < NUM_OBJ; o++) begin
        if (o >= n) r.costs[o] = $urandom;
        else r.costs[o] = r.costs[o] >> $urandom_range(0, 1);
      end
    end else if (pick < 57) begin
      // near-origin candidate that clears most of the front
      for (int o = 0; o < n; o++) r.costs[o] = 32'($urandom_range(0, 1)) << 16;
    end else if (n == 2) begin
      base       = $urandom_range(0, 40);
      r.costs[0] = 32'(base) << 16;
      r.costs[1] = 32'(40 - base + $urandom_range(0, 2)) << 16;
    end else begin
      for (int o = 0; o < n; o++) begin
        r.costs[o] = (32'($urandom_range(0, 9)) << 16) | ($urandom_range(0, 1) ? 32'h8000 : 32'h0);
      end
    end
    return r;
  endfunction

  initial begin : stimulus
    logic [2:0] settings[8];
    settings = '{3'd1, 3'd0, 3'd3, 3'd5, 3'd7, 3'd6, 3'd4, 3'd2};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = 1'b0;
    in_entry_index = '0;
    in_cost_0      = '0;
    in_cost_1      = '0;
    in_cost_2      = '0;
    in_cost_3      = '0;
    in_cost_4      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    quiet          = 1'b0;
    rx_hold_req    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, two objectives from reset
    send_request(read_at(4'd0));                          // empty front
    for (int k = 0; k < ARCHIVE_DEPTH; k++) begin         // trade-off line fills it
      maybe_idle();
      send_request(offer(32'(k) << 16, 32'(16 - k) << 16, '0, '0, '0));
    end
    send_request(offer(32'h0010_0000, '0, '0, '0, '0));   // full, nothing removed
    send_request(offer(32'h0003_0000, 32'h000d_0000, '0, '0, '0)); // equal vector
    send_request(read_at(4'd15));
    send_request(offer('0, '0, '1, '1, '1));              // clears the whole front
    send_request(read_at(4'd0));
    send_request(read_at(4'd1));
    maybe_idle();
    send_request(offer('1, '1, '1, '1, '1));
    send_request(read_at(4'd15));

    for (int p = 0; p < 8; p++) begin
      drain();
      repeat (3) @(negedge clk);
      set_active_objectives(settings[p]);
      quiet = (p == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 8) rx_hold_req = 1'b1;
        if (p == 4 && i == 20) drain();
        maybe_idle();
        send_request(random_request());
      end
    end

    drain();
    repeat (40) @(negedge clk);
    $display("Covered %0d accepted, %0d dominated, %0d dropped full, %0d reads, %0d bad index",
             sb.tally[ST_ACCEPTED], sb.tally[ST_DOMINATED], sb.tally[ST_FULL],
             sb.tally[ST_READ_OK], sb.tally[ST_BAD_INDEX]);
    $display("Objective counts 0 to 7 used; largest removal %0d, largest front %0d",
             sb.widest_removal, sb.largest_front);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_pareto_front_archive_unit passed");
    end else begin
      $display("tb_pareto_front_archive_unit failed");
    end
    $finish;
  end

endmodule
